// File: rtl/core/rau_pkg.sv
`timescale 1ns / 1ps
package rau_pkg;

  localparam int unsigned WordWidthDefault = 32;

  // Operation codes of req_type.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_OVF  = 2'd1;
  localparam logic [1:0] STAT_DIVZ = 2'd2;
  localparam logic [1:0] STAT_ZDEN = 2'd3;

endpackage

// File: rtl/core/rau_divider.sv
`timescale 1ns / 1ps
module rau_divider #(
  parameter int unsigned W = rau_pkg::WordWidthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);
  import rau_pkg::*;

  localparam int unsigned CntW = $clog2(W);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [W-1:0]    rem_q;
  logic [W-1:0]    quot_q;
  logic [W-1:0]    divisor_q;
  logic [W:0]      trial;
  logic [W:0]      diff;
  logic            ge;

  // One quotient bit per cycle, restoring form.
  assign trial = {rem_q, quot_q[W-1]};
  assign diff  = trial - {1'b0, divisor_q};
  assign ge    = trial >= {1'b0, divisor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= '0;
      quot_q    <= dividend_i;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[W-1:0] : trial[W-1:0];
      quot_q <= {quot_q[W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < divisor_q) else $error("remainder not below divisor");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done longer than one cycle");
`endif

endmodule

// File: rtl/core/rational_arith_unit.sv
`timescale 1ns / 1ps
// Zero denominator or zero divisor items go straight to the output state. Add and
// subtract run three multiplies, multiply and divide first reduce both operands and
// then run two; a result in range is then reduced to lowest terms.
// One item is in flight at a time; the bit-serial divider shared by all GCD and
// quotient steps sets the rate. Reset clears the sequencer and the output valid.
module rational_arith_unit #(
  parameter int unsigned WORD_WIDTH = rau_pkg::WordWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] a_num_i,
  input  logic [31:0] a_den_i,
  input  logic [31:0] b_num_i,
  input  logic [31:0] b_den_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] res_num_o,
  output logic [30:0] res_den_o,
  output logic [1:0]  status_o
);
  import rau_pkg::*;

  localparam int unsigned W = WORD_WIDTH;
  localparam logic [2*W-1:0] Half = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RLOAD  = 4'd1;
  localparam logic [3:0] S_RSTART = 4'd2;
  localparam logic [3:0] S_GCD    = 4'd3;
  localparam logic [3:0] S_GCDW   = 4'd4;
  localparam logic [3:0] S_DIVN   = 4'd5;
  localparam logic [3:0] S_DIVD   = 4'd6;
  localparam logic [3:0] S_RWB    = 4'd7;
  localparam logic [3:0] S_M1     = 4'd8;
  localparam logic [3:0] S_M2     = 4'd9;
  localparam logic [3:0] S_M3     = 4'd10;
  localparam logic [3:0] S_CHK    = 4'd11;
  localparam logic [3:0] S_FIN    = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;

  localparam logic [1:0] RED_A = 2'd0;
  localparam logic [1:0] RED_B = 2'd1;
  localparam logic [1:0] RED_R = 2'd2;

  logic [3:0]   state_q, state_d;
  logic         out_valid_q, out_valid_d;
  logic         accept, out_load;

  logic [1:0]   op_q, sel_q, status_q;
  logic [W-1:0] an_mag_q, ad_mag_q, bn_mag_q, bd_mag_q;
  logic         an_neg_q, ad_neg_q, bn_neg_q, bd_neg_q;
  logic [W-1:0] rn_mag_q, rd_mag_q;
  logic         rn_neg_q, rd_neg_q;
  logic [W-1:0] wn_mag_q, wd_mag_q, gx_q, gy_q, qn_q;
  logic         wn_neg_q, wd_neg_q;
  logic [2*W:0] p1_q, p2_q;
  logic [2*W-1:0] dp_mag_q;
  logic         dp_neg_q;
  logic [31:0]  res_num_q;
  logic [30:0]  res_den_q;
  logic [1:0]   res_stat_q;

  logic [W-1:0] an_w, ad_w, bn_w, bd_w;
  logic [W-1:0] mul_a, mul_b;
  logic         mul_neg;
  logic [2*W-1:0] mul_p;
  logic [2*W:0] mul_s;
  logic [2*W:0] sum, sum_abs;
  logic         ok_num, ok_den, fin_ok;
  logic [W:0]   num_s;

  logic         div_start, div_done;
  logic [W-1:0] div_dividend, div_divisor, div_quot, div_rem;

  assign an_w = a_num_i[W-1:0];
  assign ad_w = a_den_i[W-1:0];
  assign bn_w = b_num_i[W-1:0];
  assign bd_w = b_den_i[W-1:0];

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  // Shared sign-magnitude multiplier.
  always_comb begin
    mul_a   = an_mag_q;
    mul_b   = bd_mag_q;
    mul_neg = an_neg_q ^ bd_neg_q;
    unique case (state_q)
      S_M1: begin
        mul_a = an_mag_q;
        mul_b = (op_q == OP_MUL) ? bn_mag_q : bd_mag_q;
        mul_neg = an_neg_q ^ ((op_q == OP_MUL) ? bn_neg_q : bd_neg_q);
      end
      S_M2: begin
        mul_a = bn_mag_q;
        mul_b = ad_mag_q;
        mul_neg = bn_neg_q ^ ad_neg_q ^ (op_q == OP_SUB);
      end
      S_M3: begin
        mul_a = ad_mag_q;
        mul_b = (op_q == OP_DIV) ? bn_mag_q : bd_mag_q;
        mul_neg = ad_neg_q ^ ((op_q == OP_DIV) ? bn_neg_q : bd_neg_q);
      end
      default: begin
        mul_a = an_mag_q;
        mul_b = bd_mag_q;
        mul_neg = 1'b0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign mul_s = mul_neg ? -{1'b0, mul_p} : {1'b0, mul_p};

  assign sum     = p1_q + p2_q;
  assign sum_abs = sum[2*W] ? -sum : sum;
  assign ok_num  = sum[2*W] ? (sum_abs[2*W-1:0] <= Half) : (sum_abs[2*W-1:0] < Half);
  assign ok_den  = dp_neg_q ? (dp_mag_q <= Half) : (dp_mag_q < Half);

  assign fin_ok = (rn_neg_q ? ({{W{1'b0}}, rn_mag_q} <= Half)
                            : ({{W{1'b0}}, rn_mag_q} < Half))
                  && ({{W{1'b0}}, rd_mag_q} < Half);
  assign num_s  = rn_neg_q ? -{1'b0, rn_mag_q} : {1'b0, rn_mag_q};

  // Divider requests: Euclid remainders, then both quotients by the GCD.
  assign div_start    = (state_q == S_GCD) || ((state_q == S_DIVN) && div_done);
  assign div_dividend = (state_q == S_DIVN) ? wd_mag_q : ((gy_q == '0) ? wn_mag_q : gx_q);
  assign div_divisor  = ((state_q == S_DIVN) || (gy_q == '0)) ? gx_q : gy_q;

  rau_divider #(.W(W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((ad_w == '0) || (bd_w == '0) || ((req_type_i == OP_DIV) && (bn_w == '0))) begin
            state_d = S_OUT;
          end else if ((req_type_i == OP_ADD) || (req_type_i == OP_SUB)) begin
            state_d = S_M1;
          end else begin
            state_d = S_RLOAD;
          end
        end
      end
      S_RLOAD:  state_d = S_RSTART;
      S_RSTART: state_d = (wn_mag_q == '0) ? S_RWB : S_GCD;
      S_GCD:    state_d = (gy_q == '0) ? S_DIVN : S_GCDW;
      S_GCDW:   state_d = div_done ? S_GCD : S_GCDW;
      S_DIVN:   state_d = div_done ? S_DIVD : S_DIVN;
      S_DIVD:   state_d = div_done ? S_RWB : S_DIVD;
      S_RWB: begin
        unique case (sel_q)
          RED_A:   state_d = S_RLOAD;
          RED_B:   state_d = S_M1;
          default: state_d = S_FIN;
        endcase
      end
      S_M1:  state_d = ((op_q == OP_ADD) || (op_q == OP_SUB)) ? S_M2 : S_M3;
      S_M2:  state_d = S_M3;
      S_M3:  state_d = S_CHK;
      S_CHK: state_d = (ok_num && ok_den) ? S_RLOAD : S_OUT;
      S_FIN: state_d = S_OUT;
      S_OUT: state_d = out_load ? S_IDLE : S_OUT;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_q     <= req_type_i;
          sel_q    <= RED_A;
          an_neg_q <= an_w[W-1];
          ad_neg_q <= ad_w[W-1];
          bn_neg_q <= bn_w[W-1];
          bd_neg_q <= bd_w[W-1];
          an_mag_q <= an_w[W-1] ? -an_w : an_w;
          ad_mag_q <= ad_w[W-1] ? -ad_w : ad_w;
          bn_mag_q <= bn_w[W-1] ? -bn_w : bn_w;
          bd_mag_q <= bd_w[W-1] ? -bd_w : bd_w;
          if ((ad_w == '0) || (bd_w == '0)) begin
            status_q <= STAT_ZDEN;
          end else if ((req_type_i == OP_DIV) && (bn_w == '0)) begin
            status_q <= STAT_DIVZ;
          end else begin
            status_q <= STAT_OK;
          end
        end
      end
      S_RLOAD: begin
        unique case (sel_q)
          RED_A: begin
            wn_mag_q <= an_mag_q;
            wn_neg_q <= an_neg_q;
            wd_mag_q <= ad_mag_q;
            wd_neg_q <= ad_neg_q;
          end
          RED_B: begin
            wn_mag_q <= bn_mag_q;
            wn_neg_q <= bn_neg_q;
            wd_mag_q <= bd_mag_q;
            wd_neg_q <= bd_neg_q;
          end
          default: begin
            wn_mag_q <= rn_mag_q;
            wn_neg_q <= rn_neg_q;
            wd_mag_q <= rd_mag_q;
            wd_neg_q <= rd_neg_q;
          end
        endcase
      end
      S_RSTART: begin
        if (wn_mag_q == '0) begin
          // A zero value always reduces to 0/1.
          wn_neg_q <= 1'b0;
          wd_mag_q <= W'(1);
          wd_neg_q <= 1'b0;
        end else begin
          gx_q <= wn_mag_q;
          gy_q <= wd_mag_q;
        end
      end
      S_GCD: begin
      end
      S_GCDW: begin
        if (div_done) begin
          gx_q <= gy_q;
          gy_q <= div_rem;
        end
      end
      S_DIVN: begin
        if (div_done) begin
          qn_q <= div_quot;
        end
      end
      S_DIVD: begin
        if (div_done) begin
          wn_mag_q <= qn_q;
          wd_mag_q <= div_quot;
          wn_neg_q <= wn_neg_q ^ wd_neg_q;
          wd_neg_q <= 1'b0;
        end
      end
      S_RWB: begin
        unique case (sel_q)
          RED_A: begin
            an_mag_q <= wn_mag_q;
            an_neg_q <= wn_neg_q;
            ad_mag_q <= wd_mag_q;
            ad_neg_q <= wd_neg_q;
            sel_q    <= RED_B;
          end
          RED_B: begin
            bn_mag_q <= wn_mag_q;
            bn_neg_q <= wn_neg_q;
            bd_mag_q <= wd_mag_q;
            bd_neg_q <= wd_neg_q;
          end
          default: begin
            rn_mag_q <= wn_mag_q;
            rn_neg_q <= wn_neg_q;
            rd_mag_q <= wd_mag_q;
            rd_neg_q <= wd_neg_q;
          end
        endcase
      end
      S_M1: begin
        p1_q <= mul_s;
        p2_q <= '0;
      end
      S_M2: begin
        p2_q <= mul_s;
      end
      S_M3: begin
        dp_mag_q <= mul_p;
        dp_neg_q <= mul_neg;
      end
      S_CHK: begin
        rn_mag_q <= sum_abs[W-1:0];
        rn_neg_q <= sum[2*W];
        rd_mag_q <= dp_mag_q[W-1:0];
        rd_neg_q <= dp_neg_q;
        sel_q    <= RED_R;
        if (!(ok_num && ok_den)) begin
          status_q <= STAT_OVF;
        end
      end
      S_FIN: begin
        if (!fin_ok) begin
          status_q <= STAT_OVF;
        end
      end
      S_OUT: begin
        if (out_load) begin
          res_stat_q <= status_q;
          if (status_q == STAT_OK) begin
            res_num_q <= 32'($signed(num_s));
            res_den_q <= 31'(rd_mag_q);
          end else begin
            res_num_q <= '0;
            res_den_q <= '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign res_num_o   = res_num_q;
  assign res_den_o   = res_den_q;
  assign status_o    = res_stat_q;

`ifndef SYNTHESIS
  a_err_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STAT_OK)) |-> ((res_num_o == '0) && (res_den_o == '0)))
    else $error("error result not zeroed");
  a_ok_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STAT_OK)) |-> (res_den_o != '0))
    else $error("good result with zero denominator");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("accepted a beat without going busy");
`endif

endmodule

// File: test/rational_arith_unit_tb.sv
`timescale 1ns / 1ps
module rational_arith_unit_tb;
  import rau_pkg::*;

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic [1:0]  stat;
  } frac_result_t;

  localparam int unsigned IdleLimit = 200000;
  localparam int unsigned HoldCycles = 12000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i = OP_ADD;
  logic [31:0] a_num_i = '0;
  logic [31:0] a_den_i = 32'd1;
  logic [31:0] b_num_i = '0;
  logic [31:0] b_den_i = 32'd1;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] res_num_o;
  logic [30:0] res_den_o;
  logic [1:0]  status_o;

  frac_result_t expected_q[$];
  int unsigned  err_count = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  hold_cnt = 0;
  bit           hold_off = 1'b0;
  bit           stall_random = 1'b1;

  rational_arith_unit dut (.*);

  always #1 clk_i = ~clk_i;

  function automatic longint unsigned mag(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint unsigned euclid(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic void lowest_terms(inout longint n, inout longint d);
    longint g;
    if (n == 0) begin
      d = 1;
      return;
    end
    g = longint'(euclid(mag(n), mag(d)));
    n = n / g;
    d = d / g;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
  endfunction

  function automatic bit fits_word(longint x);
    return x >= -64'sd2147483648 && x <= 64'sd2147483647;
  endfunction

  function automatic frac_result_t predict_fraction(logic [1:0] op, logic [31:0] an_w,
                                                    logic [31:0] ad_w, logic [31:0] bn_w,
                                                    logic [31:0] bd_w);
    longint an, ad, bn, bd, rn, rd, p1, p2;
    logic [1:0] st;
    frac_result_t r;
    an = longint'($signed(an_w));
    ad = longint'($signed(ad_w));
    bn = longint'($signed(bn_w));
    bd = longint'($signed(bd_w));
    rn = 0;
    rd = 0;
    st = STAT_OK;
    if (ad == 0 || bd == 0) begin
      st = STAT_ZDEN;
    end else if (op == OP_DIV && bn == 0) begin
      st = STAT_DIVZ;
    end else if (op == OP_ADD || op == OP_SUB) begin
      p1 = an * bd;
      p2 = bn * ad;
      rd = ad * bd;
      if (op == OP_SUB) p2 = -p2;
      // Each product is at most 2^62 in magnitude; the only sum that wraps is 2^63,
      // which lands on -2^63 and is still flagged as out of range.
      rn = p1 + p2;
      if (!fits_word(rn) || !fits_word(rd)) st = STAT_OVF;
    end else begin
      lowest_terms(an, ad);
      lowest_terms(bn, bd);
      if (op == OP_MUL) begin
        rn = an * bn;
        rd = ad * bd;
      end else begin
        rn = an * bd;
        rd = ad * bn;
      end
      if (!fits_word(rn) || !fits_word(rd)) st = STAT_OVF;
    end
    if (st == STAT_OK) begin
      lowest_terms(rn, rd);
      if (!fits_word(rn) || !fits_word(rd)) st = STAT_OVF;
    end
    if (st != STAT_OK) begin
      rn = 0;
      rd = 0;
    end
    r.num = rn[31:0];
    r.den = rd[30:0];
    r.stat = st;
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4, 5: return $urandom;
      6: return 32'($signed($urandom_range(0, 200000)) - 100000);
      default: return 32'($signed($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  // The valid line drops only when a real gap follows, so a beat that is
  // followed at once by another never sees two drives in one time step.
  task automatic random_gap();
    int unsigned n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 300) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) n = 0;
    if (n != 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_fraction_op(logic [1:0] op, logic [31:0] an, logic [31:0] ad,
                                  logic [31:0] bn, logic [31:0] bd);
    in_valid_i <= 1'b1;
    req_type_i <= op;
    a_num_i <= an;
    a_den_i <= ad;
    b_num_i <= bn;
    b_den_i <= bd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_q.push_back(predict_fraction(op, an, ad, bn, bd));
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [31:0] mn, mx;
    mn = 32'h8000_0000;
    mx = 32'h7fff_ffff;
    send_fraction_op(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_fraction_op(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
    send_fraction_op(OP_MUL, 32'd2, 32'd3, 32'd3, 32'd4);
    send_fraction_op(OP_DIV, 32'd2, 32'd3, -32'sd4, 32'd9);
    send_fraction_op(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
    send_fraction_op(OP_DIV, 32'd1, 32'd1, 32'd5, 32'd0);
    send_fraction_op(OP_DIV, 32'd1, 32'd2, 32'd0, 32'd7);
    send_fraction_op(OP_MUL, 32'd0, mn, 32'd5, 32'd3);
    send_fraction_op(OP_ADD, mx, 32'd1, mx, 32'd1);
    send_fraction_op(OP_SUB, mn, 32'd1, 32'd1, 32'd1);
    send_fraction_op(OP_MUL, mn, 32'd1, 32'hffff_ffff, 32'd1);
    send_fraction_op(OP_DIV, mn, mn, mn, mn);
    send_fraction_op(OP_ADD, mn, mn, mx, mx);
    send_fraction_op(OP_MUL, mx, mn, mn, mx);
    send_fraction_op(OP_DIV, 32'd3, 32'hffff_fffe, 32'd5, 32'hffff_fff6);
    send_fraction_op(OP_SUB, 32'd65536, 32'd65537, 32'd65535, 32'd65536);
    send_fraction_op(OP_MUL, mn, 32'd3, 32'd1, 32'hffff_ffff);
    send_fraction_op(OP_ADD, 32'hffff_ffff, 32'd0, 32'd0, 32'd0);
  endtask

  task automatic test_backpressure();
    // The result side holds off for a fixed stretch while beats keep arriving.
    hold_off = 1'b1;
    repeat (6) send_fraction_op(2'($urandom), rand_word(), rand_word() | 32'd1,
                                rand_word(), rand_word() | 32'd1);
    hold_off = 1'b0;
    wait_all_results();
  endtask

  task automatic test_random(int unsigned count);
    logic [31:0] ad, bd;
    for (int unsigned i = 0; i < count; i++) begin
      ad = rand_word();
      bd = rand_word();
      if ($urandom_range(0, 19) != 0 && ad == 0) ad = 32'd1;
      if ($urandom_range(0, 19) != 0 && bd == 0) bd = 32'd7;
      send_fraction_op(2'($urandom), rand_word(), ad, rand_word(), bd);
      if (i == count / 2) begin
        stall_random = 1'b0;
        wait_all_results();
      end
      if (i == count * 3 / 4) stall_random = 1'b1;
      random_gap();
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_off && hold_cnt < HoldCycles) begin
      hold_cnt <= hold_cnt + 1;
      out_stall_i <= 1'b1;
    end else begin
      if (!hold_off) hold_cnt <= 0;
      if (stall_random && $urandom_range(0, 3) == 0) out_stall_i <= 1'b1;
      else out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    frac_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected");
        err_count++;
      end else begin
        exp_r = expected_q.pop_front();
        if (res_num_o !== exp_r.num) begin
          $error("res_num expected %0d got %0d", $signed(exp_r.num), $signed(res_num_o));
          err_count++;
        end
        if (res_den_o !== exp_r.den) begin
          $error("res_den expected %0d got %0d", exp_r.den, res_den_o);
          err_count++;
        end
        if (status_o !== exp_r.stat) begin
          $error("status expected %0d got %0d", exp_r.stat, status_o);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("rational_arith_unit_tb: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(1320);
    wait_all_results();
    repeat (400) @(posedge clk_i);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("rational_arith_unit_tb: PASS");
    end else begin
      $display("rational_arith_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
